### rtl/core/wde_pkg.sv
// Shared types, constants and calendar helpers for the week-of-date enumerator.
package wde_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned IdxW   = 3;

  localparam int unsigned WeekLen    = 7;
  localparam int unsigned QueueDepth = 2;

  // floor(x / 100) == (x * Recip100) >> Recip100Shift, exact for x < 43690
  localparam int unsigned Recip100      = 5243;
  localparam int unsigned Recip100Shift = 19;

  localparam logic [MonthW-1:0] January  = 4'd1;
  localparam logic [MonthW-1:0] February = 4'd2;
  localparam logic [MonthW-1:0] December = 4'd12;

  localparam logic [DayW-1:0] BaseLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Monday-of-week date handed from front to back
  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic              leap;   // leap flag of the input year, used only for February
  } monday_t;

  // month is 1..12 wherever this is called
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [3:0] idx;
    idx = 4'(m - 4'd1);
    if ((m == February) && leap) begin
      return 5'd29;
    end
    return BaseLen[idx];
  endfunction

  // floor(13 * (mm + 1) / 5) with mm the Zeller month (Jan/Feb as 13/14)
  function automatic logic [5:0] zeller_month(input logic [MonthW-1:0] m);
    logic [5:0] v;
    case (m)
      4'd1:    v = 6'd36;
      4'd2:    v = 6'd39;
      4'd3:    v = 6'd10;
      4'd4:    v = 6'd13;
      4'd5:    v = 6'd15;
      4'd6:    v = 6'd18;
      4'd7:    v = 6'd20;
      4'd8:    v = 6'd23;
      4'd9:    v = 6'd26;
      4'd10:   v = 6'd28;
      4'd11:   v = 6'd31;
      4'd12:   v = 6'd33;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/wde_if.sv
// Channel interfaces: input date and emitted week date.
interface wde_date_if;
  logic                          valid;
  logic                          ready;
  logic [wde_pkg::DayW-1:0]      day_of_month;
  logic [wde_pkg::MonthW-1:0]    month_number;
  logic [wde_pkg::YearW-1:0]     year_number;

  modport source (output valid, day_of_month, month_number, year_number, input ready);
  modport sink   (input valid, day_of_month, month_number, year_number, output ready);
endinterface

interface wde_week_if;
  logic                          valid;
  logic                          ready;
  logic [wde_pkg::DayW-1:0]      out_day;
  logic [wde_pkg::MonthW-1:0]    out_month;
  logic [wde_pkg::YearW-1:0]     out_year;
  logic [wde_pkg::IdxW-1:0]      weekday_index;
  logic                          last_of_week;

  modport source (output valid, out_day, out_month, out_year, weekday_index, last_of_week,
                  input ready);
  modport sink   (input valid, out_day, out_month, out_year, weekday_index, last_of_week,
                  output ready);
endinterface

### rtl/core/wde_front.sv
// Front: clamps the date, finds its weekday and the Monday of its week.
module wde_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  wde_date_if.sink         date_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output wde_pkg::monday_t push_data_o
);

  function automatic logic [2:0] mod7(input logic [10:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[10:9]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    s3 = s2[2:0] + 3'(s2[3]);
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

  // stage valids and load enables
  logic s1_v_q, s2_v_q, s3_v_q;
  logic ld1, ld2, ld3;

  assign ld3 = !s3_v_q || push_ready_i;
  assign ld2 = !s2_v_q || ld3;
  assign ld1 = !s1_v_q || ld2;
  assign date_i.ready = ld1;

  // stage 1: clamp month and low day, Zeller year, reciprocal products
  logic [4:0]  s1_day_q;
  logic [3:0]  s1_month_q;
  logic [13:0] s1_year_q;
  logic [14:0] s1_zyear_q;
  logic [26:0] s1_prod_y_q;
  logic [27:0] s1_prod_zy_q;

  logic [4:0]  in_day;
  logic [3:0]  in_month;
  logic [14:0] in_zyear;

  always_comb begin
    in_month = date_i.month_number;
    if (in_month < wde_pkg::January) begin
      in_month = wde_pkg::January;
    end
    if (in_month > wde_pkg::December) begin
      in_month = wde_pkg::December;
    end
    in_day = (date_i.day_of_month == 5'd0) ? 5'd1 : date_i.day_of_month;
    in_zyear = 15'(date_i.year_number) + 15'd400;
    if (in_month < 4'd3) begin
      in_zyear = in_zyear - 15'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_day_q     <= in_day;
      s1_month_q   <= in_month;
      s1_year_q    <= date_i.year_number;
      s1_zyear_q   <= in_zyear;
      s1_prod_y_q  <= 27'(date_i.year_number) * 27'(wde_pkg::Recip100);
      s1_prod_zy_q <= 28'(in_zyear) * 28'(wde_pkg::Recip100);
    end
  end

  // stage 2: leap flag, high-day clamp, Zeller sum
  logic [7:0]  cent_y;
  logic [6:0]  rem_y;
  logic [8:0]  cent_zy;
  logic [6:0]  rem_zy;
  logic        leap;
  logic [4:0]  len;
  logic [4:0]  day_c;
  logic [10:0] zsum;

  always_comb begin
    cent_y  = s1_prod_y_q[26:19];
    rem_y   = 7'(s1_year_q - 14'(cent_y) * 14'd100);
    cent_zy = s1_prod_zy_q[27:19];
    rem_zy  = 7'(s1_zyear_q - 15'(cent_zy) * 15'd100);
    leap    = (s1_year_q[1:0] == 2'd0) && ((rem_y != 7'd0) || (cent_y[1:0] == 2'd0));
    len     = wde_pkg::month_len(s1_month_q, leap);
    day_c   = (s1_day_q > len) ? len : s1_day_q;
    zsum    = 11'(day_c) + 11'(wde_pkg::zeller_month(s1_month_q)) + 11'(rem_zy)
            + 11'(rem_zy >> 2) + 11'(cent_zy >> 2) + 11'(cent_zy) * 11'd5;
  end

  logic [4:0]  s2_day_q;
  logic [3:0]  s2_month_q;
  logic [13:0] s2_year_q;
  logic        s2_leap_q;
  logic [10:0] s2_zsum_q;

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      s2_day_q   <= day_c;
      s2_month_q <= s1_month_q;
      s2_year_q  <= s1_year_q;
      s2_leap_q  <= leap;
      s2_zsum_q  <= zsum;
    end
  end

  // stage 3: weekday with Monday as 0
  logic [2:0] zh;
  logic [2:0] wd;

  assign zh = mod7(s2_zsum_q);
  assign wd = (zh < 3'd2) ? (zh + 3'd5) : (zh - 3'd2);

  logic [4:0]  s3_day_q;
  logic [3:0]  s3_month_q;
  logic [13:0] s3_year_q;
  logic        s3_leap_q;
  logic [2:0]  s3_wd_q;

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      s3_day_q   <= s2_day_q;
      s3_month_q <= s2_month_q;
      s3_year_q  <= s2_year_q;
      s3_leap_q  <= s2_leap_q;
      s3_wd_q    <= wd;
    end
  end

  // step back to Monday, borrowing from the previous month when needed
  logic [4:0] prev_len;

  always_comb begin
    push_data_o.leap = s3_leap_q;
    prev_len = 5'd31;
    if (s3_day_q > 5'(s3_wd_q)) begin
      push_data_o.day   = s3_day_q - 5'(s3_wd_q);
      push_data_o.month = s3_month_q;
      push_data_o.year  = s3_year_q;
    end else begin
      if (s3_month_q == wde_pkg::January) begin
        push_data_o.month = wde_pkg::December;
        push_data_o.year  = s3_year_q - 14'd1;
      end else begin
        push_data_o.month = s3_month_q - 4'd1;
        push_data_o.year  = s3_year_q;
        prev_len = wde_pkg::month_len(s3_month_q - 4'd1, s3_leap_q);
      end
      push_data_o.day = 5'(6'(prev_len) + 6'(s3_day_q) - 6'(s3_wd_q));
    end
  end

  assign push_valid_o = s3_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (ld1) s1_v_q <= date_i.valid;
      if (ld2) s2_v_q <= s1_v_q;
      if (ld3) s3_v_q <= s2_v_q;
    end
  end

endmodule

### rtl/core/wde_queue.sv
// Small FIFO of Monday dates between front and back.
module wde_queue #(
  parameter int unsigned Depth = wde_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  wde_pkg::monday_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output wde_pkg::monday_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wde_pkg::monday_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != CntW'(0));
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/core/wde_back.sv
// Back: walks seven dates from Monday and drives the output register.
module wde_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  wde_pkg::monday_t pop_data_i,
  wde_week_if.source       week_o
);

  localparam logic [wde_pkg::IdxW-1:0] LastIdx = wde_pkg::IdxW'(wde_pkg::WeekLen - 1);

  logic        busy_q;
  logic [2:0]  cnt_q;
  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [13:0] year_q;
  logic        leap_q;
  logic        out_v_q;

  logic emit, last, pop;
  logic [4:0]  day_d;
  logic [3:0]  month_d;
  logic [13:0] year_d;

  assign emit = busy_q && (!out_v_q || week_o.ready);
  assign last = (cnt_q == LastIdx);
  assign pop_ready_o = !busy_q || (emit && last);
  assign pop = pop_valid_i && pop_ready_o;

  // next calendar date; leap flag only matters in the Monday's own year
  always_comb begin
    day_d   = day_q + 5'd1;
    month_d = month_q;
    year_d  = year_q;
    if (day_q >= wde_pkg::month_len(month_q, leap_q)) begin
      day_d = 5'd1;
      if (month_q == wde_pkg::December) begin
        month_d = wde_pkg::January;
        year_d  = year_q + 14'd1;
      end else begin
        month_d = month_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      day_q   <= pop_data_i.day;
      month_q <= pop_data_i.month;
      year_q  <= pop_data_i.year;
      leap_q  <= pop_data_i.leap;
    end else if (emit) begin
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
    end
    if (emit) begin
      week_o.out_day       <= day_q;
      week_o.out_month     <= month_q;
      week_o.out_year      <= year_q;
      week_o.weekday_index <= cnt_q;
      week_o.last_of_week  <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (pop) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (emit) begin
        if (last) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 3'd1;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (week_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign week_o.valid = out_v_q;

endmodule

### rtl/core/week_of_date_enumerator_unit.sv
// Top level of the week-of-date enumerator: front, queue and back.
//
// Usage:
//   date_i takes one Gregorian date per transfer (valid/ready). For each date
//   week_o gives seven transfers, Monday through Sunday of that date's week,
//   with weekday_index 0..6 and last_of_week set on the Sunday.
// Path: after a date is accepted, its Monday transfer passes two more front
//   stages, the queue, the back date register and the output register
//   before it is offered.
// Throughput: set by the back part, which emits one result per cycle while
//   week_o.ready is high. The front pipeline and the queue keep taking dates
//   while the back part still works through an earlier week.
// Reset: rst_ni clears all valid flags, the queue and the back counter; no
//   result is pending after reset.
// Stall: when week_o.ready is low the output register holds its transfer and
//   the back part waits; the queue then fills and date_i.ready drops once the
//   front stages are full too. Nothing is lost or repeated.
module week_of_date_enumerator_unit #(
  parameter int unsigned QueueDepth = wde_pkg::QueueDepth
) (
  input logic        clk_i,
  input logic        rst_ni,
  wde_date_if.sink   date_i,
  wde_week_if.source week_o
);

  // front -> queue
  logic             push_valid, push_ready;
  wde_pkg::monday_t push_data;
  // queue -> back
  logic             pop_valid, pop_ready;
  wde_pkg::monday_t pop_data;

  // weekday and Monday search
  wde_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .date_i       (date_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decouples the front from output stalls
  wde_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // seven-date walk and output register
  wde_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .week_o      (week_o)
  );

endmodule

### test/week_of_date_enumerator_unit_tb.sv
// Testbench for the week-of-date enumerator: random and directed dates, checked per transfer.
`timescale 1ns / 1ps

module week_of_date_enumerator_unit_tb;

  localparam int unsigned HalfPeriod = 4;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned RandomDates = 126;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // one requested date; drain makes the sender wait for an empty scoreboard first
  typedef struct packed {
    logic [wde_pkg::DayW-1:0]   day;
    logic [wde_pkg::MonthW-1:0] month;
    logic [wde_pkg::YearW-1:0]  year;
    logic                       drain;
  } date_req_t;

  // one emitted day of the week
  typedef struct packed {
    logic [wde_pkg::DayW-1:0]   day;
    logic [wde_pkg::MonthW-1:0] month;
    logic [wde_pkg::YearW-1:0]  year;
    logic [wde_pkg::IdxW-1:0]   idx;
    logic                       last;
  } week_day_t;

  typedef enum logic [1:0] {
    RxFree,
    RxCoin,
    RxThird,
    RxHold
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wde_date_if date_if ();
  wde_week_if week_if ();

  week_of_date_enumerator_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .date_i (date_if),
    .week_o (week_if)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  date_req_t   pending_dates [$];
  week_day_t   week_expected [$];
  int unsigned errors = 0;
  int unsigned offered_cnt = 0;
  int unsigned taken_cnt = 0;

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    if (m == 2 && leap_year(y)) begin
      return 29;
    end
    return MonthDays[m - 1];
  endfunction

  // Zeller's congruence shifted so Monday is 0; +400 years keeps it positive
  function automatic int unsigned weekday_of(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned yy;
    int unsigned mm;
    int unsigned k;
    int unsigned j;
    int unsigned h;
    yy = y + 400;
    mm = m;
    if (mm < 3) begin
      mm = mm + 12;
      yy = yy - 1;
    end
    k = yy % 100;
    j = yy / 100;
    h = (d + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    return (h + 5) % 7;
  endfunction

  // Push the seven days, Monday to Sunday, of the week holding the given date
  task automatic predict_week(input logic [wde_pkg::DayW-1:0] d_in,
                              input logic [wde_pkg::MonthW-1:0] m_in,
                              input logic [wde_pkg::YearW-1:0] y_in);
    int unsigned d;
    int unsigned m;
    int unsigned wd;
    logic [wde_pkg::YearW-1:0] y;
    week_day_t e;
    d = d_in;
    m = m_in;
    y = y_in;
    // out-of-range months and days are clamped
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > days_in(m, y)) d = days_in(m, y);
    wd = weekday_of(d, m, y);
    // back to Monday, possibly into the previous month or year (year wraps in 14 bits)
    if (d > wd) begin
      d = d - wd;
    end else begin
      if (m == 1) begin
        m = 12;
        y = y - 1'b1;
      end else begin
        m = m - 1;
      end
      d = days_in(m, y) - (wd - d);
    end
    for (int i = 0; i < 7; i++) begin
      e.day   = d[wde_pkg::DayW-1:0];
      e.month = m[wde_pkg::MonthW-1:0];
      e.year  = y;
      e.idx   = i[wde_pkg::IdxW-1:0];
      e.last  = (i == 6);
      week_expected.push_back(e);
      d = d + 1;
      if (d > days_in(m, y)) begin
        d = 1;
        m = m + 1;
        if (m > 12) begin
          m = 1;
          y = y + 1'b1;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic add_date(input int unsigned d, input int unsigned m, input int unsigned y,
                          input bit drain);
    date_req_t r;
    r.day   = d[wde_pkg::DayW-1:0];
    r.month = m[wde_pkg::MonthW-1:0];
    r.year  = y[wde_pkg::YearW-1:0];
    r.drain = drain;
    pending_dates.push_back(r);
  endtask

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 2499) * 4;                     // leap candidates
      1: return $urandom_range(0, 163) * 100;                    // century years
      2: begin
        case ($urandom_range(0, 2))
          0: return $urandom_range(0, 3);
          1: return $urandom_range(9996, 10003);
          default: return $urandom_range(16380, 16383);
        endcase
      end
      3: return $urandom_range(10000, 16383);
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of transfers with random gaps; holds each item until taken
  // ---------------------------------------------------------------------------
  date_req_t   cur_date;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      date_if.valid <= 1'b0;
    end else if (date_if.valid && (taken_cnt != offered_cnt)) begin
      // offered item not yet accepted: keep it on the bus
    end else if (gap_left > 0) begin
      date_if.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_dates.size() == 0 ||
                 (pending_dates[0].drain && week_expected.size() != 0)) begin
      // nothing left, or a drain point waiting for every outstanding day
      date_if.valid <= 1'b0;
    end else begin
      cur_date = pending_dates.pop_front();
      date_if.valid        <= 1'b1;
      date_if.day_of_month <= cur_date.day;
      date_if.month_number <= cur_date.month;
      date_if.year_number  <= cur_date.year;
      offered_cnt <= offered_cnt + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern switches among free, coin flip, one-in-three, and
  // free with occasional long holds
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode = RxFree;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick = 0;
  int unsigned rx_hold_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      week_if.ready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_e'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(20, 150);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RxFree:  week_if.ready <= 1'b1;
        RxCoin:  week_if.ready <= 1'($urandom_range(0, 1));
        RxThird: week_if.ready <= (rx_tick % 3 == 0);
        default: begin
          if (rx_hold_left > 0) begin
            week_if.ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
          end else begin
            week_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) rx_hold_left <= $urandom_range(1, 20);
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input transfer, check each output transfer
  // ---------------------------------------------------------------------------
  week_day_t got_exp;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (date_if.valid && date_if.ready) begin
        predict_week(date_if.day_of_month, date_if.month_number, date_if.year_number);
        taken_cnt <= taken_cnt + 1;
      end
      if (week_if.valid && week_if.ready) begin
        if (week_expected.size() == 0) begin
          $display("%0t: unexpected transfer, expected none actual %0d-%0d-%0d idx %0d",
                   $time, week_if.out_year, week_if.out_month, week_if.out_day,
                   week_if.weekday_index);
          errors++;
        end else begin
          got_exp = week_expected.pop_front();
          check_field("out_day",       got_exp.day,   week_if.out_day);
          check_field("out_month",     got_exp.month, week_if.out_month);
          check_field("out_year",      got_exp.year,  week_if.out_year);
          check_field("weekday_index", got_exp.idx,   week_if.weekday_index);
          check_field("last_of_week",  got_exp.last,  week_if.last_of_week);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned len;
    date_if.valid        = 1'b0;
    date_if.day_of_month = '0;
    date_if.month_number = '0;
    date_if.year_number  = '0;
    week_if.ready        = 1'b0;

    // directed dates
    add_date(29, 2, 2024, 0);    // leap day
    add_date(29, 2, 2023, 0);    // Feb 29 in a common year, clamps to 28
    add_date(29, 2, 1900, 0);    // century, not leap
    add_date(29, 2, 2000, 0);    // 400-year leap
    add_date(0, 3, 2021, 0);     // day zero
    add_date(31, 4, 2021, 0);    // day past month end
    add_date(15, 0, 2021, 0);    // month zero
    add_date(10, 13, 2021, 0);   // months above December
    add_date(31, 15, 2021, 0);
    add_date(1, 1, 0, 0);        // year zero, week starts in year 16383
    add_date(29, 2, 0, 0);       // year zero is leap
    add_date(1, 1, 1, 0);
    add_date(31, 12, 9999, 0);
    add_date(31, 12, 16383, 0);  // week runs into year 0
    add_date(28, 12, 16383, 0);
    add_date(1, 1, 2021, 0);     // back into previous December
    add_date(1, 3, 2024, 0);     // back into a leap February
    add_date(1, 3, 2023, 0);     // back into a common February
    add_date(31, 12, 2020, 0);   // forward into January
    add_date(1, 1, 2024, 0);     // Monday itself
    add_date(7, 1, 2024, 0);     // Sunday
    add_date(31, 15, 16383, 0);  // all field bits high
    add_date(0, 0, 0, 0);        // all field bits low
    add_date(15, 6, 10000, 0);

    // random dates; the first one waits for the directed weeks to drain
    for (int n = 0; n < RandomDates; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          // raw noise across the whole field ranges
          d = $urandom_range(0, 31);
          m = $urandom_range(0, 15);
          y = $urandom_range(0, 16383);
        end
        3, 4, 5, 6: begin
          // first or last week of a month, mostly at year ends
          m = ($urandom_range(0, 1) == 0) ? (($urandom_range(0, 1) == 0) ? 1 : 12)
                                          : $urandom_range(1, 12);
          y = pick_year();
          len = days_in(m, y);
          d = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 7) : $urandom_range(len - 6, len);
        end
        default: begin
          m = $urandom_range(1, 12);
          y = pick_year();
          d = $urandom_range(1, days_in(m, y));
        end
      endcase
      add_date(d, m, y, (n == 0) || ($urandom_range(0, 40) == 0));
    end

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_dates.size() != 0 || date_if.valid || week_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
